// ===== rtl/mm4_pkg.sv =====
// shared types and constants of the 4x4 fixed-point matrix multiplier
// no dependencies; used by the interfaces, the lanes, the merge stage and the top level
package mm4_pkg;

  localparam int unsigned DIM    = 4;
  localparam int unsigned IDX_W  = $clog2(DIM);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC   = 16;
  localparam int unsigned PROD_W = 2 * DATA_W;
  // floor-shifted products summed over DIM terms without overflow
  localparam int unsigned ACC_W  = PROD_W - FRAC + IDX_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // tag that travels alongside the lane pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    idx_t col;
  } lane_ctl_t;

endpackage

// ===== rtl/mm4_if.sv =====
// valid/ready channels for column words in and product column words out
// depends on mm4_pkg
interface mm4_in_if;
  logic           valid;
  logic           ready;
  mm4_pkg::data_t a_elem0;
  mm4_pkg::data_t a_elem1;
  mm4_pkg::data_t a_elem2;
  mm4_pkg::data_t a_elem3;
  mm4_pkg::data_t b_elem0;
  mm4_pkg::data_t b_elem1;
  mm4_pkg::data_t b_elem2;
  mm4_pkg::data_t b_elem3;

  modport source (
    output valid, a_elem0, a_elem1, a_elem2, a_elem3,
    output b_elem0, b_elem1, b_elem2, b_elem3,
    input  ready
  );
  modport sink (
    input  valid, a_elem0, a_elem1, a_elem2, a_elem3,
    input  b_elem0, b_elem1, b_elem2, b_elem3,
    output ready
  );
endinterface

interface mm4_out_if;
  logic           valid;
  logic           ready;
  mm4_pkg::data_t prod_elem0;
  mm4_pkg::data_t prod_elem1;
  mm4_pkg::data_t prod_elem2;
  mm4_pkg::data_t prod_elem3;
  logic [1:0]     column_index;
  logic           last_column;

  modport source (
    output valid, prod_elem0, prod_elem1, prod_elem2, prod_elem3,
    output column_index, last_column,
    input  ready
  );
  modport sink (
    input  valid, prod_elem0, prod_elem1, prod_elem2, prod_elem3,
    input  column_index, last_column,
    output ready
  );
endinterface

// ===== rtl/matrix_multiply_4x4_unit.sv =====
// 4x4 Q16.16 matrix multiplier, product = a * b, one column of a and b per input word
// product column words follow once the fourth column is taken, one multiplier per row lane, four products each;
// no column word is taken while a pair's products are issued, and issue stalls while the output word is held
// reset: clears the column count, sequencer and valid flags; the column stores are not cleared
// depends on mm4_pkg, mm4_if, mm4_lane and mm4_merge
module matrix_multiply_4x4_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  mm4_in_if.sink    in_i,
  mm4_out_if.source out_o
);

  localparam int unsigned CNT_W = 2 * mm4_pkg::IDX_W;

  typedef enum logic {ST_LOAD, ST_RUN} state_e;

  state_e             state_q;
  mm4_pkg::idx_t      cols_q;
  logic [CNT_W-1:0]   cnt_q;
  mm4_pkg::lane_ctl_t ctl1_q, ctl2_q;

  mm4_pkg::data_t a_col [mm4_pkg::DIM];
  mm4_pkg::data_t b_col [mm4_pkg::DIM];
  mm4_pkg::data_t b_store_q [mm4_pkg::DIM][mm4_pkg::DIM];
  mm4_pkg::acc_t  sums [mm4_pkg::DIM];

  logic          accept;
  logic          adv;
  logic          issue;
  mm4_pkg::idx_t k_idx, i_idx;
  mm4_pkg::data_t b_sel;

  // unpack the input word
  assign a_col[0] = in_i.a_elem0;
  assign a_col[1] = in_i.a_elem1;
  assign a_col[2] = in_i.a_elem2;
  assign a_col[3] = in_i.a_elem3;
  assign b_col[0] = in_i.b_elem0;
  assign b_col[1] = in_i.b_elem1;
  assign b_col[2] = in_i.b_elem2;
  assign b_col[3] = in_i.b_elem3;

  assign in_i.ready = (state_q == ST_LOAD);
  assign accept     = in_i.valid && in_i.ready;
  assign issue      = (state_q == ST_RUN);
  assign k_idx      = cnt_q[mm4_pkg::IDX_W-1:0];
  assign i_idx      = cnt_q[CNT_W-1:mm4_pkg::IDX_W];
  assign b_sel      = b_store_q[i_idx][k_idx];

  // column store of matrix b
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int r = 0; r < mm4_pkg::DIM; r++) begin
        b_store_q[cols_q][r] <= b_col[r];
      end
    end
  end

  // sequencer: load columns, then issue DIM x DIM products per lane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cols_q  <= '0;
      cnt_q   <= '0;
      ctl1_q  <= '0;
      ctl2_q  <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (accept) begin
            cols_q <= cols_q + 1'b1;
            if (cols_q == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1)) begin
              state_q <= ST_RUN;
              cnt_q   <= '0;
            end
          end
        end
        ST_RUN: begin
          if (adv) begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CNT_W'(mm4_pkg::DIM * mm4_pkg::DIM - 1)) begin
              state_q <= ST_LOAD;
              cols_q  <= '0;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
      if (adv) begin
        ctl1_q.valid <= issue;
        ctl1_q.first <= (k_idx == '0);
        ctl1_q.last  <= (k_idx == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1));
        ctl1_q.col   <= i_idx;
        ctl2_q       <= ctl1_q;
      end
    end
  end

  // one lane per product row
  for (genvar j = 0; j < mm4_pkg::DIM; j++) begin : g_lane
    mm4_lane u_lane (
      .clk_i      (clk_i),
      .load_i     (accept),
      .load_col_i (cols_q),
      .a_elem_i   (a_col[j]),
      .k_i        (k_idx),
      .b_elem_i   (b_sel),
      .adv_i      (adv),
      .ctl_i      (ctl2_q),
      .sum_o      (sums[j])
    );
  end

  // saturate and hold the finished column
  mm4_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl2_q),
    .sum_i  (sums),
    .adv_o  (adv),
    .out_o  (out_o)
  );

  // fourth column starts the issue sweep from its beginning
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cols_q == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1)) |=>
      (state_q == ST_RUN && cnt_q == '0))
    else $error("issue sweep did not start after the last column");

  // every issue cycle that advances enters the lane pipeline
  a_issue_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && adv) |=> ctl1_q.valid)
    else $error("issued product lost its tag");

  // a completed dot product lands in the output register
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl2_q.valid && ctl2_q.last && adv) |=> out_o.valid)
    else $error("finished column not presented");

  // last mark only on the final product column
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_column) |->
      (out_o.column_index == 2'(mm4_pkg::DIM - 1)))
    else $error("last mark on wrong column");

endmodule

// ===== rtl/mm4_lane.sv =====
// one row lane: holds a row of matrix a, multiplies and accumulates one dot product
// depends on mm4_pkg
module mm4_lane (
  input  logic                clk_i,
  input  logic                load_i,
  input  mm4_pkg::idx_t       load_col_i,
  input  mm4_pkg::data_t      a_elem_i,
  input  mm4_pkg::idx_t       k_i,
  input  mm4_pkg::data_t      b_elem_i,
  input  logic                adv_i,
  input  mm4_pkg::lane_ctl_t  ctl_i,
  output mm4_pkg::acc_t       sum_o
);

  mm4_pkg::data_t a_row_q [mm4_pkg::DIM];
  mm4_pkg::data_t opa_q, opb_q;
  mm4_pkg::prod_t prod_q;
  mm4_pkg::acc_t  acc_q;
  mm4_pkg::acc_t  shifted;

  // row store, one element per loaded column
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_row_q[load_col_i] <= a_elem_i;
    end
  end

  // operand fetch, multiply and accumulate stages
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      opa_q  <= a_row_q[k_i];
      opb_q  <= b_elem_i;
      prod_q <= opa_q * opb_q;
      if (ctl_i.valid) begin
        acc_q <= sum_o;
      end
    end
  end

  // arithmetic shift drops the fraction bits, rounding toward minus infinity
  assign shifted = mm4_pkg::ACC_W'(prod_q >>> mm4_pkg::FRAC);
  assign sum_o   = (ctl_i.first ? '0 : acc_q) + shifted;

endmodule

// ===== rtl/mm4_merge.sv =====
// merge stage: saturates the lane sums and holds the product column word
// depends on mm4_pkg and mm4_if
module mm4_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mm4_pkg::lane_ctl_t  ctl_i,
  input  mm4_pkg::acc_t       sum_i [mm4_pkg::DIM],
  output logic                adv_o,
  mm4_out_if.source           out_o
);

  logic           valid_q;
  mm4_pkg::idx_t  col_q;
  logic           last_q;
  mm4_pkg::data_t data_q [mm4_pkg::DIM];
  logic           done;

  function automatic mm4_pkg::data_t sat32(input mm4_pkg::acc_t v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[mm4_pkg::ACC_W-1:mm4_pkg::DATA_W-1];
    hi_zeros = ~|v[mm4_pkg::ACC_W-1:mm4_pkg::DATA_W-1];
    if (hi_ones || hi_zeros) begin
      return v[mm4_pkg::DATA_W-1:0];
    end else if (v[mm4_pkg::ACC_W-1]) begin
      return {1'b1, {(mm4_pkg::DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(mm4_pkg::DATA_W-1){1'b1}}};
    end
  endfunction

  // pipeline moves whenever the output register is free or being drained
  assign adv_o = !valid_q || out_o.ready;
  assign done  = ctl_i.valid && ctl_i.last;

  // output word valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= done;
    end
  end

  // output word tags and payload
  always_ff @(posedge clk_i) begin
    if (adv_o && done) begin
      col_q  <= ctl_i.col;
      last_q <= (ctl_i.col == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1));
      for (int j = 0; j < mm4_pkg::DIM; j++) begin
        data_q[j] <= sat32(sum_i[j]);
      end
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.prod_elem0   = data_q[0];
  assign out_o.prod_elem1   = data_q[1];
  assign out_o.prod_elem2   = data_q[2];
  assign out_o.prod_elem3   = data_q[3];
  assign out_o.column_index = 2'(col_q);
  assign out_o.last_column  = last_q;

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the 4x4 Q16.16 matrix multiplier: column words in, product words out
// depends on mm4_pkg, mm4_in_if, mm4_out_if and matrix_multiply_4x4_unit
module tb_top;
  import mm4_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned RANDOM_PAIRS   = 113;
  localparam int unsigned CALM_PAIRS     = 20;
  localparam int unsigned HOLD_PAIR      = 20;
  localparam int unsigned PAUSE_PAIR     = 50;

  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;

  localparam data_t Q_MAX     = 32'sh7fff_ffff;
  localparam data_t Q_MIN     = 32'sh8000_0000;
  localparam data_t Q_ONE     = 32'sh0001_0000;
  localparam data_t Q_NEG_ONE = -32'sh0001_0000;
  localparam data_t Q_LSB     = 32'sd1;
  localparam data_t Q_NEG_LSB = -32'sd1;

  // flavours of random element values
  typedef enum int unsigned {
    VAL_FULL,
    VAL_SMALL,
    VAL_EXTREME,
    VAL_MIXED
  } val_mode_e;

  typedef data_t mat_t [DIM*DIM];

  typedef struct {
    data_t a[DIM];
    data_t b[DIM];
  } col_pair_t;

  typedef struct {
    data_t      elem[DIM];
    logic [1:0] col;
    logic       last;
  } prod_col_t;

  // column store copy and queue of product words still owed by the block
  class product_board;
    data_t       left_cols[DIM*DIM];
    data_t       right_cols[DIM*DIM];
    int unsigned cols_loaded;
    prod_col_t   expected[$];

    function new();
      cols_loaded = 0;
    endfunction

    function data_t clamp32(longint v);
      if (v > SAT_MAX) return Q_MAX;
      if (v < SAT_MIN) return Q_MIN;
      return data_t'(v);
    endfunction

    // store one accepted column word; on the fourth, work out all product columns
    function void note_column(col_pair_t w);
      int unsigned c;
      longint      acc;
      prod_col_t   res;
      c = cols_loaded;
      for (int r = 0; r < DIM; r++) begin
        left_cols[c*DIM+r]  = w.a[r];
        right_cols[c*DIM+r] = w.b[r];
      end
      if (c != DIM - 1) begin
        cols_loaded = c + 1;
        return;
      end
      cols_loaded = 0;
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          acc = 0;
          // each product floored to Q16.16, sum kept wide
          for (int k = 0; k < DIM; k++) begin
            acc += (longint'(left_cols[k*DIM+j]) * longint'(right_cols[i*DIM+k])) >>> FRAC;
          end
          res.elem[j] = clamp32(acc);
        end
        res.col  = 2'(i);
        res.last = (i == DIM - 1);
        expected.push_back(res);
      end
    endfunction

    // compare one product word with the oldest expectation; empty string when it matches
    function string check_column(prod_col_t got);
      string     msg;
      prod_col_t want;
      msg = "";
      if (expected.size() == 0) begin
        return $sformatf("product word for column %0d with nothing expected", got.col);
      end
      want = expected.pop_front();
      for (int j = 0; j < DIM; j++) begin
        if (got.elem[j] !== want.elem[j]) begin
          msg = {msg, $sformatf(" elem%0d got %h exp %h", j, got.elem[j], want.elem[j])};
        end
      end
      if (got.col !== want.col) begin
        msg = {msg, $sformatf(" column_index got %0d exp %0d", got.col, want.col)};
      end
      if (got.last !== want.last) begin
        msg = {msg, $sformatf(" last_column got %b exp %b", got.last, want.last)};
      end
      if (msg != "") begin
        msg = {$sformatf("column %0d:", want.col), msg};
      end
      return msg;
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mm4_in_if  in_if ();
  mm4_out_if out_if ();

  matrix_multiply_4x4_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  product_board board = new();
  int unsigned  mismatches = 0;
  bit           idle_on = 1'b1;
  bit           hold_req = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // offer one column word and wait for it to be taken
  task automatic send_column(input col_pair_t w);
    in_if.valid   <= 1'b1;
    in_if.a_elem0 <= w.a[0];
    in_if.a_elem1 <= w.a[1];
    in_if.a_elem2 <= w.a[2];
    in_if.a_elem3 <= w.a[3];
    in_if.b_elem0 <= w.b[0];
    in_if.b_elem1 <= w.b[1];
    in_if.b_elem2 <= w.b[2];
    in_if.b_elem3 <= w.b[3];
    do @(posedge clk); while (!in_if.ready);
  endtask

  // random idle burst on the sending side
  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_pair(input mat_t a, input mat_t b);
    col_pair_t w;
    for (int c = 0; c < DIM; c++) begin
      for (int r = 0; r < DIM; r++) begin
        w.a[r] = a[c*DIM+r];
        w.b[r] = b[c*DIM+r];
      end
      send_column(w);
      maybe_gap();
    end
  endtask

  function automatic mat_t const_mat(input data_t v);
    mat_t m;
    for (int n = 0; n < DIM*DIM; n++) m[n] = v;
    return m;
  endfunction

  function automatic mat_t ident_mat();
    mat_t m;
    for (int n = 0; n < DIM*DIM; n++) m[n] = (n % (DIM + 1) == 0) ? Q_ONE : '0;
    return m;
  endfunction

  function automatic data_t rand_elem(input val_mode_e mode);
    val_mode_e pick;
    data_t     v;
    pick = (mode == VAL_MIXED) ? val_mode_e'($urandom_range(0, 2)) : mode;
    case (pick)
      VAL_FULL: begin
        v = data_t'($urandom);
      end
      VAL_SMALL: begin
        // within about +-8.0, where products stay in range
        v = data_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      end
      default: begin
        case ($urandom_range(0, 7))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = '0;
          3:       v = Q_LSB;
          4:       v = Q_NEG_LSB;
          5:       v = Q_ONE;
          6:       v = Q_NEG_ONE;
          default: v = data_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic mat_t rand_mat(input val_mode_e mode);
    mat_t m;
    for (int n = 0; n < DIM*DIM; n++) m[n] = rand_elem(mode);
    return m;
  endfunction

  // input side monitor feeds the predictor
  always @(posedge clk) begin : take_column
    col_pair_t w;
    if (rst_n && in_if.valid && in_if.ready) begin
      w.a[0] = in_if.a_elem0;
      w.a[1] = in_if.a_elem1;
      w.a[2] = in_if.a_elem2;
      w.a[3] = in_if.a_elem3;
      w.b[0] = in_if.b_elem0;
      w.b[1] = in_if.b_elem1;
      w.b[2] = in_if.b_elem2;
      w.b[3] = in_if.b_elem3;
      board.note_column(w);
    end
  end

  // output side monitor checks each product word
  always @(posedge clk) begin : take_product
    prod_col_t got;
    string     msg;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.elem[0] = out_if.prod_elem0;
      got.elem[1] = out_if.prod_elem1;
      got.elem[2] = out_if.prod_elem2;
      got.elem[3] = out_if.prod_elem3;
      got.col     = out_if.column_index;
      got.last    = out_if.last_column;
      msg = board.check_column(got);
      if (msg != "") report_mismatch(msg);
    end
  end

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // reset, directed pairs, random pairs, drain
  initial begin
    val_mode_e mode;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.a_elem0 <= '0;
    in_if.a_elem1 <= '0;
    in_if.a_elem2 <= '0;
    in_if.a_elem3 <= '0;
    in_if.b_elem0 <= '0;
    in_if.b_elem1 <= '0;
    in_if.b_elem2 <= '0;
    in_if.b_elem3 <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity passes the most negative value through exactly
    send_pair(ident_mat(), const_mat(Q_MIN));
    // positive and negative saturation
    send_pair(const_mat(Q_MAX), const_mat(Q_MAX));
    send_pair(const_mat(Q_MAX), const_mat(Q_MIN));
    send_pair(const_mat(Q_MIN), const_mat(Q_MIN));
    // truncation of negative products rounds towards minus infinity
    send_pair(const_mat(Q_NEG_LSB), const_mat(Q_LSB));
    // full-range left operand against zero
    send_pair(rand_mat(VAL_FULL), const_mat('0));

    for (int unsigned p = 0; p < RANDOM_PAIRS; p++) begin
      if (p == RANDOM_PAIRS - CALM_PAIRS) idle_on = 1'b0;
      if (p == HOLD_PAIR) hold_req = 1'b1;
      if (p == PAUSE_PAIR) begin
        // sender waits until the block has handed over everything
        in_if.valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      mode = val_mode_e'($urandom_range(0, 3));
      if (p == 0) send_pair(const_mat(Q_MAX), ident_mat());
      else send_pair(rand_mat(mode), rand_mat(mode));
    end

    in_if.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== matrix_multiply_4x4_unit.f =====
rtl/mm4_pkg.sv
rtl/mm4_if.sv
rtl/mm4_lane.sv
rtl/mm4_merge.sv
rtl/matrix_multiply_4x4_unit.sv
dv/tb_top.sv
